/* rtl/core/tlpt_pkg.sv */
// shared types and constants of the two-level page table updater
package tlpt_pkg;

  localparam int unsigned POOL_PAGES_DEF    = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned IDX_W             = 10;
  localparam int unsigned PAGE_W            = 20;
  localparam int unsigned DIR_SHIFT         = 22;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam logic [PAGE_W-1:0] POOL_BASE_RST = 20'd256;

  localparam logic [1:0] MODE_MAP   = 2'd0;
  localparam logic [1:0] MODE_UNMAP = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_e;

  // 23-bit table entry
  typedef struct packed {
    logic [PAGE_W-1:0] frame;
    logic              user;
    logic              writ;
    logic              present;
  } entry_t;

endpackage

/* rtl/core/tlpt_ram.sv */
// single-port-write, single-port-read table pool memory with registered read data
module tlpt_ram #(
  parameter int unsigned DEPTH = tlpt_pkg::POOL_PAGES_DEF * tlpt_pkg::ENTRIES_PER_TABLE,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tlpt_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output tlpt_pkg::entry_t rdata_o
);

  tlpt_pkg::entry_t mem [DEPTH];
  tlpt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/two_level_page_table_updater.sv */
// two-level page table updater: table pool memory and its sequencer
//
// Input channel (in_valid_i / in_stall_o) takes one transaction: mode, directory
// page, virtual and physical address, user and writable bits. Output channel
// (out_valid_o / out_stall_i) returns one transaction per input: result_page
// and status. The configuration channel (cfg_valid_i / cfg_ready_o) writes
// pool_base_page; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this.
// States from input acceptance to result valid: map into an existing page table:
//   S_DIR, S_WDIR, S_WTAB, S_DONE; unmap: S_DIR, S_TRD, S_DONE; mode 3 or
//   directory outside the pool: S_DONE; directory entry error: S_DIR, S_DONE
//   allocate: S_ZERO, S_DONE; map needing a new page table: S_DIR, S_ZERO,
//   S_WDIR, S_WTAB, S_DONE, where zeroing the page writes one entry per cycle
// One transaction is processed at a time; in_stall_o is high while busy and
// drops once the result is loaded into the output register.
// A stalled receiver holds the next result back only once it is finished,
// and the next transaction may be accepted while the previous result still waits.
// Reset sets pool_base_page to 256 and the free page counter to zero. The
// pool memory is not cleared; pages are zeroed when they are handed out.
module two_level_page_table_updater #(
  parameter int unsigned POOL_PAGES = tlpt_pkg::POOL_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [19:0] dir_page_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic        user_access_i,
  input  logic        writable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] result_page_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IW    = tlpt_pkg::IDX_W;
  localparam int unsigned PW    = tlpt_pkg::PAGE_W;
  localparam int unsigned OW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned DEPTH = POOL_PAGES * tlpt_pkg::ENTRIES_PER_TABLE;
  localparam int unsigned AW    = OW + IW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR,
    S_TRD,
    S_ZERO,
    S_WDIR,
    S_WTAB,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [1:0]          mode_q;
  logic [IW-1:0]       di_q, ti_q;
  logic [PW-1:0]       frame_q;
  logic                us_q, rw_q;
  logic [OW-1:0]       doff_q, toff_q;
  tlpt_pkg::entry_t    dir_ent_q;
  logic [PW-1:0]       result_q;
  tlpt_pkg::status_e   status_q;
  logic [IW-1:0]       cnt_q;
  logic [CW-1:0]       next_free_q;
  logic [PW-1:0]       base_q;
  logic                out_valid_q;
  logic [PW-1:0]       out_page_q;
  tlpt_pkg::status_e   out_status_q;

  logic [PW-1:0]       in_off, fr_off;
  logic                dir_in, fr_in, exhausted;
  logic [OW-1:0]       noff;
  logic [IW-1:0]       di_in, ti_in;
  tlpt_pkg::entry_t    ent;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  tlpt_pkg::entry_t    ram_wdata;

  tlpt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ent)
  );

  // pool membership of the incoming directory and of the fetched entry's frame
  assign in_off    = dir_page_i - base_q;
  assign dir_in    = in_off < PW'(POOL_PAGES);
  assign fr_off    = ent.frame - base_q;
  assign fr_in     = fr_off < PW'(POOL_PAGES);
  assign exhausted = next_free_q == CW'(POOL_PAGES);
  assign noff      = next_free_q[OW-1:0];
  assign di_in     = virt_addr_i[tlpt_pkg::DIR_SHIFT +: IW];
  assign ti_in     = virt_addr_i[tlpt_pkg::PAGE_SHIFT +: IW];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {toff_q, cnt_q};
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {in_off[OW-1:0], di_in};
    case (state_q)
      S_IDLE: begin
        ram_re = in_valid_i;
      end
      S_DIR: begin
        ram_re    = 1'b1;
        ram_raddr = {fr_off[OW-1:0], ti_q};
      end
      S_TRD: begin
        ram_we            = 1'b1;
        ram_waddr         = {toff_q, ti_q};
        ram_wdata         = ent;
        ram_wdata.present = 1'b0;
      end
      S_ZERO: begin
        ram_we = 1'b1;
      end
      S_WDIR: begin
        ram_we    = 1'b1;
        ram_waddr = {doff_q, di_q};
        ram_wdata = dir_ent_q;
      end
      S_WTAB: begin
        ram_we            = 1'b1;
        ram_waddr         = {toff_q, ti_q};
        ram_wdata.present = 1'b1;
        ram_wdata.writ    = rw_q;
        ram_wdata.user    = us_q;
        ram_wdata.frame   = frame_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= tlpt_pkg::MODE_MAP;
      di_q         <= '0;
      ti_q         <= '0;
      frame_q      <= '0;
      us_q         <= 1'b0;
      rw_q         <= 1'b0;
      doff_q       <= '0;
      toff_q       <= '0;
      dir_ent_q    <= '0;
      result_q     <= '0;
      status_q     <= tlpt_pkg::ST_OK;
      cnt_q        <= '0;
      next_free_q  <= '0;
      base_q       <= tlpt_pkg::POOL_BASE_RST;
      out_valid_q  <= 1'b0;
      out_page_q   <= '0;
      out_status_q <= tlpt_pkg::ST_OK;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      // in S_DONE the output register is reloaded below instead
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            di_q    <= di_in;
            ti_q    <= ti_in;
            frame_q <= phys_addr_i[tlpt_pkg::PAGE_SHIFT +: PW];
            us_q    <= user_access_i;
            rw_q    <= writable_i;
            doff_q  <= in_off[OW-1:0];
            cnt_q   <= '0;
            if (mode_i == tlpt_pkg::MODE_MAP || mode_i == tlpt_pkg::MODE_UNMAP) begin
              result_q <= '0;
              if (dir_in) begin
                status_q <= tlpt_pkg::ST_OK;
                state_q  <= S_DIR;
              end else begin
                status_q <= tlpt_pkg::ST_OUTSIDE;
                state_q  <= S_DONE;
              end
            end else if (mode_i == tlpt_pkg::MODE_ALLOC) begin
              if (exhausted) begin
                result_q <= '0;
                status_q <= tlpt_pkg::ST_EXHAUSTED;
                state_q  <= S_DONE;
              end else begin
                toff_q      <= noff;
                next_free_q <= next_free_q + 1'b1;
                result_q    <= base_q + PW'(noff);
                status_q    <= tlpt_pkg::ST_OK;
                state_q     <= S_ZERO;
              end
            end else begin
              result_q <= '0;
              status_q <= tlpt_pkg::ST_OK;
              state_q  <= S_DONE;
            end
          end
        end
        S_DIR: begin
          if (mode_q == tlpt_pkg::MODE_UNMAP) begin
            if (fr_in) begin
              toff_q  <= fr_off[OW-1:0];
              state_q <= S_TRD;
            end else begin
              status_q <= tlpt_pkg::ST_OUTSIDE;
              state_q  <= S_DONE;
            end
          end else if (!ent.present) begin
            // no page table yet: take and zero a fresh pool page
            if (exhausted) begin
              status_q <= tlpt_pkg::ST_EXHAUSTED;
              state_q  <= S_DONE;
            end else begin
              dir_ent_q   <= {base_q + PW'(noff), us_q, ent.writ | rw_q, 1'b1};
              toff_q      <= noff;
              next_free_q <= next_free_q + 1'b1;
              state_q     <= S_ZERO;
            end
          end else if (fr_in) begin
            dir_ent_q <= {ent.frame, ent.user, ent.writ | rw_q, ent.present};
            toff_q    <= fr_off[OW-1:0];
            state_q   <= S_WDIR;
          end else begin
            status_q <= tlpt_pkg::ST_OUTSIDE;
            state_q  <= S_DONE;
          end
        end
        S_TRD: begin
          result_q <= ent.frame;
          state_q  <= S_DONE;
        end
        S_ZERO: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            state_q <= (mode_q == tlpt_pkg::MODE_MAP) ? S_WDIR : S_DONE;
          end
        end
        S_WDIR: begin
          state_q <= S_WTAB;
        end
        S_WTAB: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_page_q   <= result_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign result_page_o = out_page_q;
  assign status_o      = out_status_q;

endmodule
